### hw/rtl/aup_pkg.sv
// Shared types and character constants for the ASCII unsigned integer parser.
`timescale 1ns / 1ps
`default_nettype none
package aup_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int BASE_BITS   = 6;
	localparam int VALUE_BITS  = 64;
	localparam int CHAR_BITS   = 8;

	localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;
	localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CHAR_BITS-1:0] CHAR_0     = 8'h30;
	localparam logic [CHAR_BITS-1:0] CHAR_9     = 8'h39;
	localparam logic [CHAR_BITS-1:0] CHAR_UC_A  = 8'h41;
	localparam logic [CHAR_BITS-1:0] CHAR_UC_X  = 8'h58;
	localparam logic [CHAR_BITS-1:0] CHAR_UC_Z  = 8'h5A;
	localparam logic [CHAR_BITS-1:0] CHAR_LC_A  = 8'h61;
	localparam logic [CHAR_BITS-1:0] CHAR_LC_X  = 8'h78;
	localparam logic [CHAR_BITS-1:0] CHAR_LC_Z  = 8'h7A;

	localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
	localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
	localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
	localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;
	localparam logic [BASE_BITS-1:0] DIGIT_ALPHA_OFS = 6'd10;

	typedef struct packed {
		logic                 start;
		logic                 alnum;
		logic [BASE_BITS-1:0] digit;
		logic                 space;
		logic                 zero;
		logic                 hex_x;
	} entry_t;

endpackage
`default_nettype wire

### hw/rtl/aup_if.sv
// Valid/ready channel interfaces for parser items and results.
`timescale 1ns / 1ps
`default_nettype none
interface aup_char_if;
	logic       valid;
	logic       ready;
	logic       string_start;
	logic [7:0] char_code;

	modport source (output valid, output string_start, output char_code, input ready);
	modport sink (input valid, input string_start, input char_code, output ready);
endinterface

interface aup_result_if #(
	parameter int OFFSET_BITS = 16
);
	logic                   valid;
	logic                   ready;
	logic [63:0]            parsed_value;
	logic [OFFSET_BITS-1:0] stop_offset;

	modport source (output valid, output parsed_value, output stop_offset, input ready);
	modport sink (input valid, input parsed_value, input stop_offset, output ready);
endinterface
`default_nettype wire

### hw/rtl/ascii_unsigned_integer_parser.sv
// ASCII unsigned integer parser: character items in, at most one result per string out.
// A result is registered when its stopping item is popped from the queue.
// One item per cycle unless the output stalls; the 64x6 multiply-add is combinational.
// A two-entry queue lets the front keep accepting while a result waits on the output.
// Reset: parse idle, base register 0, queue and result register empty.
`timescale 1ns / 1ps
`default_nettype none
module ascii_unsigned_integer_parser #(
	parameter int OFFSET_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [aup_pkg::BASE_BITS-1:0] cfg_wdata,
	aup_char_if.sink                           char_item,
	aup_result_if.source                       result_item
);
	import aup_pkg::*;

	logic [BASE_BITS-1:0] base_cfg_q;
	logic                 q_push;
	logic                 q_not_full;
	logic                 q_pop;
	logic                 q_not_empty;
	entry_t               q_entry;
	entry_t               q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_cfg_q <= BASE_AUTO;
		end else if (cfg_we) begin
			base_cfg_q <= cfg_wdata;
		end
	end

	aup_front u_front (
		.char_item (char_item),
		.q_ready   (q_not_full),
		.q_push    (q_push),
		.q_entry   (q_entry)
	);

	aup_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.not_full   (q_not_full),
		.pop        (q_pop),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	aup_back #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_base    (base_cfg_q),
		.q_valid     (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.result_item (result_item)
	);
endmodule
`default_nettype wire

### hw/rtl/aup_front.sv
// Front end: accept character items and classify them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module aup_front (
	aup_char_if.sink        char_item,
	input  wire logic       q_ready,
	output logic            q_push,
	output aup_pkg::entry_t q_entry
);
	import aup_pkg::*;

	logic [CHAR_BITS-1:0] c;
	logic                 is_num;
	logic                 is_upper;
	logic                 is_lower;

	assign c        = char_item.char_code;
	assign is_num   = (c >= CHAR_0) && (c <= CHAR_9);
	assign is_upper = (c >= CHAR_UC_A) && (c <= CHAR_UC_Z);
	assign is_lower = (c >= CHAR_LC_A) && (c <= CHAR_LC_Z);

	assign char_item.ready = q_ready;
	assign q_push          = char_item.valid && q_ready;

	always_comb begin
		q_entry.start = char_item.string_start;
		q_entry.alnum = is_num || is_upper || is_lower;
		q_entry.space = (c == CHAR_SPACE);
		q_entry.zero  = (c == CHAR_0);
		q_entry.hex_x = (c == CHAR_LC_X) || (c == CHAR_UC_X);
		if (is_num) begin
			q_entry.digit = BASE_BITS'(c - CHAR_0);
		end else if (is_upper) begin
			q_entry.digit = BASE_BITS'(c - CHAR_UC_A) + DIGIT_ALPHA_OFS;
		end else if (is_lower) begin
			q_entry.digit = BASE_BITS'(c - CHAR_LC_A) + DIGIT_ALPHA_OFS;
		end else begin
			q_entry.digit = '0;
		end
	end
endmodule
`default_nettype wire

### hw/rtl/aup_queue.sv
// Short FIFO of classified items between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module aup_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  aup_pkg::entry_t      push_entry,
	output logic                 not_full,
	input  wire logic            pop,
	output logic                 not_empty,
	output aup_pkg::entry_t      head
);
	import aup_pkg::*;

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);
	localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);

	entry_t              mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign not_full  = (count_q != CNT_FULL);
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

### hw/rtl/aup_back.sv
// Back end: parse state, multiply-accumulate and the result register.
`timescale 1ns / 1ps
`default_nettype none
module aup_back #(
	parameter int OFFSET_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [aup_pkg::BASE_BITS-1:0] cfg_base,
	input  wire logic                          q_valid,
	input  aup_pkg::entry_t                    q_head,
	output logic                               q_pop,
	aup_result_if.source                       result_item
);
	import aup_pkg::*;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_LEAD   = 2'd1;
	localparam logic [1:0] PH_ZERO   = 2'd2;
	localparam logic [1:0] PH_DIGITS = 2'd3;

	logic [1:0]                      phase_q;
	logic [BASE_BITS-1:0]            base_q;
	logic [VALUE_BITS-1:0]           value_q;
	logic [OFFSET_BITS-1:0]          pos_q;
	logic                            out_valid_q;
	logic [VALUE_BITS-1:0]           out_value_q;
	logic [OFFSET_BITS-1:0]          out_pos_q;

	logic [1:0]                      ph_e;
	logic [1:0]                      ph_n;
	logic [BASE_BITS-1:0]            b;
	logic [VALUE_BITS-1:0]           v;
	logic [OFFSET_BITS-1:0]          p;
	logic                            digits_now;
	logic                            acc;
	logic                            adv;
	logic                            emit;
	logic [VALUE_BITS+BASE_BITS-1:0] prod;
	logic [VALUE_BITS-1:0]           v_n;
	logic [OFFSET_BITS-1:0]          p_n;

	assign q_pop = q_valid && (!out_valid_q || result_item.ready);

	always_comb begin
		ph_e = phase_q;
		b    = base_q;
		v    = value_q;
		p    = pos_q;
		if (q_head.start) begin
			ph_e = PH_LEAD;
			b    = cfg_base;
			v    = '0;
			p    = '0;
		end
		ph_n       = ph_e;
		digits_now = 1'b0;
		acc        = 1'b0;
		adv        = 1'b0;
		emit       = 1'b0;
		case (ph_e)
			PH_LEAD: begin
				if (q_head.space) begin
					adv = 1'b1;
				end else if (b == BASE_AUTO) begin
					if (q_head.zero) begin
						ph_n = PH_ZERO;
						adv  = 1'b1;
					end else begin
						b          = BASE_DEC;
						digits_now = 1'b1;
					end
				end else begin
					digits_now = 1'b1;
				end
			end
			PH_ZERO: begin
				if (q_head.hex_x) begin
					b    = BASE_HEX;
					ph_n = PH_DIGITS;
					adv  = 1'b1;
				end else begin
					b          = BASE_OCT;
					digits_now = 1'b1;
				end
			end
			PH_DIGITS: begin
				digits_now = 1'b1;
			end
			default: begin
			end
		endcase
		if (digits_now) begin
			if (q_head.alnum && (q_head.digit < b)) begin
				acc  = 1'b1;
				adv  = 1'b1;
				ph_n = PH_DIGITS;
			end else begin
				emit = 1'b1;
				ph_n = PH_IDLE;
			end
		end
		prod = v * b;
		v_n  = acc ? (prod[VALUE_BITS-1:0] + VALUE_BITS'(q_head.digit)) : v;
		p_n  = (adv && (p != '1)) ? p + 1'b1 : p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			base_q      <= '0;
			value_q     <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q <= ph_n;
				base_q  <= b;
				value_q <= v_n;
				pos_q   <= p_n;
			end
			if (q_pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (result_item.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			out_value_q <= v;
			out_pos_q   <= p;
		end
	end

	assign result_item.valid        = out_valid_q;
	assign result_item.parsed_value = out_value_q;
	assign result_item.stop_offset  = out_pos_q;
endmodule
`default_nettype wire

### test/ascii_unsigned_integer_parser_tb.sv
// Testbench for the ASCII unsigned integer parser: random and directed strings, checked per result.
`timescale 1ns / 1ps
module ascii_unsigned_integer_parser_tb;
	import aup_pkg::*;

	localparam int OFFSET_BITS  = 16;
	localparam int RANDOM_ITEMS = 1100;
	localparam int SETTLE       = 8;
	localparam int LONG_HOLD    = 300;

	typedef enum logic [1:0] {PH_IDLE, PH_LEADING, PH_AFTER_ZERO, PH_DIGITS} parse_phase_e;

	typedef struct packed {
		logic                 start;
		logic [CHAR_BITS-1:0] code;
	} text_byte_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0]  value;
		logic [OFFSET_BITS-1:0] offset;
	} number_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [BASE_BITS-1:0] cfg_wdata;

	aup_char_if chars_if();
	aup_result_if #(.OFFSET_BITS(OFFSET_BITS)) results_if();

	ascii_unsigned_integer_parser #(.OFFSET_BITS(OFFSET_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.char_item(chars_if),
		.result_item(results_if)
	);

	text_byte_t pending_bytes[$];
	number_t expected_numbers[$];

	logic [BASE_BITS-1:0]   base_reg;
	parse_phase_e           phase;
	logic [BASE_BITS-1:0]   active_radix;
	logic [VALUE_BITS-1:0]  accum;
	logic [OFFSET_BITS-1:0] position;

	int mismatch_count;
	int random_items;
	logic open_string;
	int burst_left;
	int gap_left;
	int hold_left;
	logic long_hold_req;
	int stall_tick;
	int stall_mode;
	number_t want;
	number_t got;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic char_digit(input logic [CHAR_BITS-1:0] c,
			output logic [BASE_BITS-1:0] d);
		d = '0;
		if (c >= CHAR_0 && c <= CHAR_9) begin
			d = BASE_BITS'(c - CHAR_0);
			return 1'b1;
		end
		if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
			d = BASE_BITS'(c - CHAR_LC_A) + DIGIT_ALPHA_OFS;
			return 1'b1;
		end
		if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
			d = BASE_BITS'(c - CHAR_UC_A) + DIGIT_ALPHA_OFS;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [OFFSET_BITS-1:0] bump(input logic [OFFSET_BITS-1:0] p);
		return (p == '1) ? p : p + 1'b1;
	endfunction

	task automatic predict_byte(input logic start, input logic [CHAR_BITS-1:0] c);
		logic ok;
		logic [BASE_BITS-1:0] d;
		number_t r;
		if (start) begin
			phase = PH_LEADING;
			active_radix = base_reg;
			accum = '0;
			position = '0;
		end
		if (phase == PH_IDLE)
			return;
		if (phase == PH_LEADING) begin
			if (c == CHAR_SPACE) begin
				position = bump(position);
				return;
			end
			if (active_radix == BASE_AUTO) begin
				if (c == CHAR_0) begin
					phase = PH_AFTER_ZERO;
					position = bump(position);
					return;
				end
				active_radix = BASE_DEC;
			end
			phase = PH_DIGITS;
		end else if (phase == PH_AFTER_ZERO) begin
			if (c == CHAR_LC_X || c == CHAR_UC_X) begin
				active_radix = BASE_HEX;
				phase = PH_DIGITS;
				position = bump(position);
				return;
			end
			active_radix = BASE_OCT;
			phase = PH_DIGITS;
		end
		ok = char_digit(c, d);
		if (ok && d < active_radix) begin
			accum = accum * VALUE_BITS'(active_radix) + VALUE_BITS'(d);
			position = bump(position);
			return;
		end
		r.value = accum;
		r.offset = position;
		expected_numbers.push_back(r);
		phase = PH_IDLE;
	endtask

	task automatic report_mismatch(input string what, input number_t exp_r, input number_t act_r);
		if (mismatch_count < 10)
			$display("mismatch (%s): expected value %h offset %0d, got value %h offset %0d",
				what, exp_r.value, exp_r.offset, act_r.value, act_r.offset);
		mismatch_count++;
	endtask

	task automatic push_byte(input logic start, input logic [CHAR_BITS-1:0] c);
		text_byte_t b;
		b.start = start;
		b.code = c;
		pending_bytes.push_back(b);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(i == 0, s[i]);
	endtask

	task automatic emit(input logic [CHAR_BITS-1:0] c);
		push_byte(open_string, c);
		open_string = 1'b0;
		random_items++;
	endtask

	function automatic logic [CHAR_BITS-1:0] digit_char(input int d);
		if (d < 10)
			return CHAR_0 + CHAR_BITS'(d);
		return ($urandom_range(0, 1) ? CHAR_LC_A : CHAR_UC_A) + CHAR_BITS'(d - 10);
	endfunction

	task automatic write_base(input logic [BASE_BITS-1:0] b);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= b;
		@(posedge clk);
		cfg_we <= 1'b0;
		base_reg = b;
	endtask

	task automatic wait_idle();
		do begin
			while (pending_bytes.size() != 0 || chars_if.valid || expected_numbers.size() != 0)
				@(posedge clk);
			repeat (SETTLE) @(posedge clk);
		end while (pending_bytes.size() != 0 || chars_if.valid || expected_numbers.size() != 0);
	endtask

	task automatic gen_number_string();
		int radix;
		int ndig;
		logic [CHAR_BITS-1:0] c;
		logic [BASE_BITS-1:0] d;
		open_string = 1'b1;
		radix = (base_reg == BASE_AUTO) ? 10 : int'(base_reg);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 4)) emit(CHAR_SPACE);
		if (base_reg == BASE_AUTO) begin
			case ($urandom_range(0, 3))
				0: begin
					emit(CHAR_0);
					emit($urandom_range(0, 1) ? CHAR_LC_X : CHAR_UC_X);
					radix = 16;
				end
				1: begin
					emit(CHAR_0);
					radix = 8;
				end
				default: ;
			endcase
		end
		ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 26) : $urandom_range(0, 10);
		repeat (ndig) emit(digit_char($urandom_range(0, (radix > 36) ? 35 : radix - 1)));
		case ($urandom_range(0, 4))
			0: emit(CHAR_NUL);
			1: begin
				c = CHAR_BITS'($urandom_range(0, 255));
				while (char_digit(c, d))
					c = CHAR_BITS'($urandom_range(0, 255));
				emit(c);
			end
			2: emit((radix < 36) ? digit_char($urandom_range(radix, 35)) : CHAR_NUL);
			3: emit(CHAR_BITS'($urandom_range(0, 255)));
			default: ;
		endcase
		repeat ($urandom_range(0, 2)) push_byte(1'b0, CHAR_BITS'($urandom_range(0, 255)));
	endtask

	// driver: bursts of items with random gaps, hold the item while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_if.valid <= 1'b0;
			chars_if.string_start <= 1'b0;
			chars_if.char_code <= CHAR_NUL;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (chars_if.valid && chars_if.ready)
				predict_byte(chars_if.string_start, chars_if.char_code);
			if (!chars_if.valid || chars_if.ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					chars_if.valid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					chars_if.valid <= 1'b1;
					{chars_if.string_start, chars_if.char_code} <= pending_bytes.pop_front();
					if (burst_left <= 1) begin
						burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
							: $urandom_range(1, 12);
						gap_left <= $urandom_range(0, 5);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					chars_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (long_hold_req)
			hold_left <= LONG_HOLD;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
			stall_tick <= 0;
			stall_mode <= 0;
		end else begin
			stall_tick <= stall_tick + 1;
			if (stall_tick % 128 == 0)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: results_if.ready <= (hold_left == 0);
				1: results_if.ready <= (hold_left == 0) && ($urandom_range(0, 1) == 1);
				2: results_if.ready <= (hold_left == 0) && (stall_tick % 4 == 0);
				default: results_if.ready <= (hold_left == 0) && ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready) begin
			got.value = results_if.parsed_value;
			got.offset = results_if.stop_offset;
			if (expected_numbers.size() == 0) begin
				report_mismatch("no result pending", '0, got);
			end else begin
				want = expected_numbers.pop_front();
				if (got.value !== want.value)
					report_mismatch("parsed_value", want, got);
				else if (got.offset !== want.offset)
					report_mismatch("stop_offset", want, got);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		logic [BASE_BITS-1:0] b;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		long_hold_req = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.string_start = 1'b0;
		chars_if.char_code = CHAR_NUL;
		results_if.ready = 1'b0;
		base_reg = BASE_AUTO;
		phase = PH_IDLE;
		active_radix = '0;
		accum = '0;
		position = '0;
		mismatch_count = 0;
		random_items = 0;
		open_string = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// prefix detection, restart, empty prefix, bytes while idle
		push_byte(1'b0, CHAR_9);
		push_text(" 0x1F");
		push_byte(1'b0, CHAR_NUL);
		push_byte(1'b0, 8'hFF);
		push_text("0179");
		push_text("0xg");
		push_text("12");
		push_text("5.");
		push_text(" ,");
		push_text("7");
		wait_idle();

		// base change lands mid-string, then radix one
		write_base(6'd1);
		push_byte(1'b0, CHAR_9);
		push_byte(1'b0, CHAR_NUL);
		push_text("0012");
		push_byte(1'b0, CHAR_LC_X);
		wait_idle();

		write_base(6'd63);
		push_text("zZ9-");
		wait_idle();

		// long receiver hold-off while the sender keeps going
		@(posedge clk);
		long_hold_req <= 1'b1;
		@(posedge clk);
		long_hold_req <= 1'b0;
		repeat (60) begin
			open_string = 1'b1;
			emit(digit_char($urandom_range(0, 9)));
			emit(CHAR_NUL);
		end
		wait_idle();

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2: b = BASE_AUTO;
				3: b = BASE_DEC;
				4: b = BASE_HEX;
				5: b = BASE_OCT;
				6: b = 6'd2;
				7: b = 6'd36;
				8: b = 6'd1;
				default: b = BASE_BITS'($urandom_range(0, 63));
			endcase
			write_base(b);
			repeat ($urandom_range(4, 30)) begin
				if ($urandom_range(0, 7) == 0) begin
					open_string = $urandom_range(0, 1);
					repeat ($urandom_range(1, 6)) emit(CHAR_BITS'($urandom_range(0, 255)));
				end else begin
					gen_number_string();
				end
			end
			wait_idle();
		end

		if (mismatch_count == 0 && expected_numbers.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
